// ----- src/spcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types and constants of the serial position command parser.
// ----------------------------------------------------------------------------
package spcp_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 7;
  localparam int CODE_W  = 3;
  localparam int CIDX_W  = 2;

  localparam int LINE_MAX_DEF = 32;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [CODE_W-1:0] {
    REPLY_ENABLED  = 3'd0,
    REPLY_DISABLED = 3'd1,
    REPLY_POSITION = 3'd2,
    REPLY_SYS_OFF  = 3'd3,
    REPLY_BAD      = 3'd4
  } reply_code_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_POS_MIN   = 2'd0,
    CFG_POS_MAX   = 2'd1,
    CFG_STEP_SIZE = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_t;

  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_E     = 8'h65;
  localparam byte_t CH_D     = 8'h64;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_NUL   = 8'h00;

  localparam pos_t POS_MIN_RST  = 7'd10;
  localparam pos_t POS_MAX_RST  = 7'd90;
  localparam pos_t STEP_RST     = 7'd5;
  localparam pos_t POSITION_RST = 7'd10;

endpackage

`default_nettype wire

// ----- src/spcp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcp channels
// Valid/ready channels for received bytes and for replies.
// ----------------------------------------------------------------------------
interface spcp_byte_if;
  logic              valid;
  logic              ready;
  spcp_pkg::byte_t   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spcp_reply_if;
  logic                  valid;
  logic                  ready;
  spcp_pkg::reply_code_t reply_code;
  spcp_pkg::pos_t        current_position;

  modport source (output valid, output reply_code, output current_position, input ready);
  modport sink   (input valid, input reply_code, input current_position, output ready);
endinterface

`default_nettype wire

// ----- src/serial_position_command_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_position_command_parser
// Gathers received bytes into CR/LF terminated lines and answers each
// non-empty line with one reply code and the current position.
//
// Usage:
//   rx_chan carries one received byte per transfer. reply_chan carries one
//   reply per closed non-empty line: reply_code and current_position.
//   Bytes are taken at one per cycle while rx_chan ready is high; it drops
//   when the skid register is full and returns the cycle after reply_chan
//   takes a transfer. A terminator byte puts its reply in the output
//   register, or in the skid register if the output register is full; other
//   bytes produce none. With an output register and a one-entry skid
//   register, a stalled receiver blocks rx_chan only once both hold a
//   reply. Lines reaching LINE_MAX bytes are dropped without a reply.
//   Limits and step size are written through cfg_write / cfg_index /
//   cfg_data; index 3 is ignored. The user must write them only while the
//   block is idle; the block does not enforce it. Reset (rst, synchronous)
//   empties the reply buffer, clears the line, disables the system, sets
//   position to 10 and loads the default limits 10 and 90 and step size 5.
// ----------------------------------------------------------------------------
module serial_position_command_parser #(
  parameter int LINE_MAX = spcp_pkg::LINE_MAX_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_write,
  input  wire [spcp_pkg::CIDX_W-1:0]    cfg_index,
  input  wire [spcp_pkg::POS_W-1:0]     cfg_data,
  spcp_byte_if.sink                     rx_chan,
  spcp_reply_if.source                  reply_chan
);
  import spcp_pkg::*;

  localparam int LC_W = $clog2(LINE_MAX);

  pos_t pos_min;
  pos_t pos_max;
  pos_t step_size;

  logic [LC_W-1:0] line_count;
  logic [1:0]      eff_length;
  logic            zero_seen;
  byte_t           first_char;
  byte_t           second_char;
  logic            enabled_flag;
  pos_t            position;

  logic            out_valid;
  reply_code_t     out_code;
  pos_t            out_pos;
  logic            skid_valid;
  reply_code_t     skid_code;
  pos_t            skid_pos;

  logic            accept;
  logic            is_term;
  logic            push;
  logic            pop;
  logic [LC_W:0]   lc_inc;
  logic            wrap;

  reply_code_t     code_next;
  pos_t            position_next;
  logic            enabled_next;
  logic [POS_W:0]  sum;
  logic [POS_W:0]  diff;
  pos_t            digit_val;
  logic            first_digit;
  logic            second_digit;

  assign rx_chan.ready = !skid_valid;
  assign accept  = rx_chan.valid && rx_chan.ready;
  assign is_term = (rx_chan.rx_byte == CH_CR) || (rx_chan.rx_byte == CH_LF);
  assign push    = accept && is_term && (line_count != '0);
  assign pop     = reply_chan.valid && reply_chan.ready;
  assign lc_inc  = {1'b0, line_count} + {{LC_W{1'b0}}, 1'b1};
  assign wrap    = lc_inc >= (LC_W+1)'(LINE_MAX);

  assign sum          = {1'b0, position} + {1'b0, step_size};
  assign diff         = {1'b0, position} - {1'b0, step_size};
  assign first_digit  = (first_char >= CH_ZERO) && (first_char <= CH_NINE);
  assign second_digit = (second_char >= CH_ZERO) && (second_char <= CH_NINE);
  assign digit_val    = {first_char[3:0], 3'b000} + {2'b00, first_char[3:0], 1'b0}
                      + {3'b000, second_char[3:0]};

  always_comb begin
    code_next     = REPLY_BAD;
    position_next = position;
    enabled_next  = enabled_flag;
    if (eff_length == 2'd1 && first_char == CH_E) begin
      enabled_next = 1'b1;
      code_next    = REPLY_ENABLED;
    end else if (eff_length == 2'd1 && first_char == CH_D) begin
      enabled_next = 1'b0;
      code_next    = REPLY_DISABLED;
    end else if (eff_length == 2'd1 && first_char == CH_PLUS) begin
      if (!enabled_flag) begin
        code_next = REPLY_SYS_OFF;
      end else begin
        code_next     = REPLY_POSITION;
        position_next = (sum > {1'b0, pos_max}) ? pos_max : sum[POS_W-1:0];
      end
    end else if (eff_length == 2'd1 && first_char == CH_MINUS) begin
      if (!enabled_flag) begin
        code_next = REPLY_SYS_OFF;
      end else begin
        code_next     = REPLY_POSITION;
        position_next = (diff[POS_W] || diff[POS_W-1:0] < pos_min) ? pos_min
                                                                   : diff[POS_W-1:0];
      end
    end else if (eff_length == 2'd2 && first_digit && second_digit) begin
      if (digit_val < pos_min || digit_val > pos_max) begin
        code_next = REPLY_BAD;
      end else if (!enabled_flag) begin
        code_next = REPLY_SYS_OFF;
      end else begin
        code_next     = REPLY_POSITION;
        position_next = digit_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_min   <= POS_MIN_RST;
      pos_max   <= POS_MAX_RST;
      step_size <= STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_POS_MIN:   pos_min   <= cfg_data;
        CFG_POS_MAX:   pos_max   <= cfg_data;
        CFG_STEP_SIZE: step_size <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      eff_length   <= '0;
      zero_seen    <= 1'b0;
      first_char   <= '0;
      second_char  <= '0;
      enabled_flag <= 1'b0;
      position     <= POSITION_RST;
    end else if (accept) begin
      if (is_term) begin
        if (line_count != '0) begin
          enabled_flag <= enabled_next;
          position     <= position_next;
          line_count   <= '0;
          eff_length   <= '0;
          zero_seen    <= 1'b0;
        end
      end else begin
        if (line_count == '0) begin
          first_char <= rx_chan.rx_byte;
        end
        if (line_count == LC_W'(1)) begin
          second_char <= rx_chan.rx_byte;
        end
        if (wrap) begin
          line_count <= '0;
          eff_length <= '0;
          zero_seen  <= 1'b0;
        end else begin
          line_count <= lc_inc[LC_W-1:0];
          if (!zero_seen) begin
            if (rx_chan.rx_byte == CH_NUL) begin
              zero_seen <= 1'b1;
            end else if (eff_length != 2'd3) begin
              eff_length <= eff_length + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_code <= skid_code;
        out_pos  <= skid_pos;
      end else begin
        out_code <= code_next;
        out_pos  <= position_next;
      end
    end
    if (out_valid && !pop && !skid_valid) begin
      skid_code <= code_next;
      skid_pos  <= position_next;
    end
  end

  assign reply_chan.valid            = out_valid;
  assign reply_chan.reply_code       = out_code;
  assign reply_chan.current_position = out_pos;

endmodule

`default_nettype wire
